### rtl/core/bcat_pkg.sv
// Shared types and constants for the block chain allocation table.
// Holds the request/result item structs and the controller/datapath command and status structs.
// Depends on nothing.
`default_nettype none

package bcat_pkg;

	localparam int ENTRIES_DEF = 2048;

	localparam logic [15:0] CHAIN_END = 16'hFFFF;

	// Request codes.
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [10:0] block_count;
		logic [10:0] entry_index;
	} bcat_req_t;

	typedef struct packed {
		logic        status;
		logic [15:0] value;
	} bcat_rsp_t;

	// Which result the datapath builds for the current item.
	typedef enum logic [2:0] {
		RK_ZERO,
		RK_END,
		RK_FAIL,
		RK_HEAD,
		RK_LINK
	} bcat_res_t;

	typedef struct packed {
		logic      load;
		logic      clear;
		logic      scan_init;
		logic      scan;
		logic      link;
		logic      term;
		logic      free_start;
		logic      free_step;
		logic      read_issue;
		logic      res_load;
		bcat_res_t res_kind;
		logic      out_load;
	} bcat_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       count_zero;
		logic       clr_last;
		logic       scan_done;
		logic       scan_exh;
		logic       idx_ok;
		logic       walk_go;
	} bcat_sts_t;

endpackage

`default_nettype wire

### rtl/core/bcat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module bcat_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/bcat_datapath.sv
// Datapath of the allocation table: link memory, scan and walk counters, result registers.
// Depends on bcat_pkg and bcat_ram; driven by bcat_ctrl through bcat_cmd_t.
`default_nettype none

module bcat_datapath #(
	parameter int ENTRIES = bcat_pkg::ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bcat_pkg::bcat_req_t req_in,
	input  wire bcat_pkg::bcat_cmd_t cmd,
	output bcat_pkg::bcat_sts_t      sts,
	output bcat_pkg::bcat_rsp_t      rsp
);

	import bcat_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] ENT_C    = CNT_W'(ENTRIES);
	localparam logic [15:0]      ENT_L    = 16'(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [1:0]       req_type_q;
	logic [10:0]      count_q;
	logic [15:0]      idx_q;
	logic [CNT_W-1:0] steps_q;
	logic [CNT_W-1:0] addr_q;
	logic [10:0]      found_q;
	logic [IDX_W-1:0] prev_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] clr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	bcat_rsp_t        res_q;
	bcat_rsp_t        rsp_q;
	bcat_rsp_t        res_n;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [15:0]      ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [15:0]      ram_rdata;

	logic             hit;
	logic [10:0]      found_n;
	logic             scan_done;
	logic             scan_exh;
	logic             issue_ok;
	logic             idx_ok;
	logic [CNT_W-1:0] steps_n;
	logic             walk_go;

	bcat_ram #(
		.WIDTH(16),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The scan reads one entry per cycle; rd_vld_s1 marks the entry whose link arrives now.
	assign hit       = rd_vld_s1 && (ram_rdata == 16'd0);
	assign found_n   = found_q + 11'd1;
	assign scan_done = hit && (found_n == count_q);
	assign scan_exh  = rd_vld_s1 && (rd_idx_s1 == LAST_IDX) && !scan_done;
	assign issue_ok  = cmd.scan && (addr_q < ENT_C) && !scan_done && !scan_exh;

	assign idx_ok  = (idx_q != 16'd0) && (idx_q < ENT_L);
	assign steps_n = steps_q + CNT_W'(1);
	// A link that points back at its own entry would read its old link again, as the zero is written
	// in the same cycle as that read, so the walk ends there as well.
	assign walk_go = (ram_rdata != 16'd0) && (ram_rdata < ENT_L) && (steps_n < ENT_C) &&
		(ram_rdata != idx_q);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q[IDX_W-1:0];
		priority if (cmd.scan) begin
			ram_re    = issue_ok;
			ram_raddr = addr_q[IDX_W-1:0];
		end else if (cmd.free_step) begin
			ram_re    = walk_go;
			ram_raddr = ram_rdata[IDX_W-1:0];
		end else if (cmd.free_start) begin
			ram_re = idx_ok;
		end else if (cmd.read_issue) begin
			ram_re = 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = prev_q;
		ram_wdata = 16'd0;
		priority if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (cmd.free_step) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q[IDX_W-1:0];
		end else if (cmd.term) begin
			ram_we    = 1'b1;
			ram_wdata = CHAIN_END;
		end else if (cmd.scan && cmd.link && hit && (found_q != 11'd0)) begin
			ram_we    = 1'b1;
			ram_wdata = 16'(rd_idx_s1);
		end
	end

	always_comb begin
		res_n = '0;
		unique case (cmd.res_kind)
			RK_END:  res_n.value = CHAIN_END;
			RK_FAIL: res_n.status = 1'b1;
			RK_HEAD: res_n.value = 16'(head_q);
			RK_LINK: res_n.value = (idx_q < ENT_L) ? ram_rdata : 16'd0;
			default: res_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			rd_vld_s1 <= issue_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_in.req_type;
			count_q    <= req_in.block_count;
			idx_q      <= 16'(req_in.entry_index);
		end
		if (cmd.scan_init) begin
			addr_q  <= CNT_W'(1);
			found_q <= '0;
		end
		if (cmd.scan) begin
			if (issue_ok) begin
				addr_q    <= addr_q + CNT_W'(1);
				rd_idx_s1 <= addr_q[IDX_W-1:0];
			end
			if (hit) begin
				found_q <= found_n;
				prev_q  <= rd_idx_s1;
				if (found_q == 11'd0) begin
					head_q <= rd_idx_s1;
				end
			end
		end
		if (cmd.free_start) begin
			steps_q <= '0;
		end
		if (cmd.free_step) begin
			idx_q   <= ram_rdata;
			steps_q <= steps_n;
		end
		if (cmd.res_load) begin
			res_q <= res_n;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.req_type   = req_type_q;
		sts.count_zero = (count_q == 11'd0);
		sts.clr_last   = (clr_q == LAST_IDX);
		sts.scan_done  = scan_done;
		sts.scan_exh   = scan_exh;
		sts.idx_ok     = idx_ok;
		sts.walk_go    = walk_go;
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

### rtl/core/bcat_ctrl.sv
// Controller state machine of the allocation table: sequences clear, allocate, free and read.
// Depends on bcat_pkg; drives bcat_datapath through bcat_cmd_t and reads bcat_sts_t.
`default_nettype none

module bcat_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	input  wire bcat_pkg::bcat_sts_t sts,
	output bcat_pkg::bcat_cmd_t      cmd
);

	import bcat_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN_CNT,
		ST_LINK_INIT,
		ST_SCAN_LINK,
		ST_TERM,
		ST_FREE_WALK,
		ST_READ_WAIT,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.req_type)
					REQ_ALLOC: begin
						if (sts.count_zero) begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RK_END;
							state_n      = ST_RESP;
						end else begin
							cmd.scan_init = 1'b1;
							state_n       = ST_SCAN_CNT;
						end
					end
					REQ_FREE: begin
						cmd.free_start = 1'b1;
						if (sts.idx_ok) begin
							state_n = ST_FREE_WALK;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RK_ZERO;
							state_n      = ST_RESP;
						end
					end
					REQ_READ: begin
						cmd.read_issue = 1'b1;
						state_n        = ST_READ_WAIT;
					end
					default: begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RK_ZERO;
						state_n      = ST_RESP;
					end
				endcase
			end
			ST_SCAN_CNT: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_n = ST_LINK_INIT;
				end else if (sts.scan_exh) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RK_FAIL;
					state_n      = ST_RESP;
				end
			end
			ST_LINK_INIT: begin
				cmd.scan_init = 1'b1;
				state_n       = ST_SCAN_LINK;
			end
			ST_SCAN_LINK: begin
				cmd.scan = 1'b1;
				cmd.link = 1'b1;
				if (sts.scan_done) begin
					state_n = ST_TERM;
				end
			end
			ST_TERM: begin
				cmd.term     = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_kind = RK_HEAD;
				state_n      = ST_RESP;
			end
			ST_FREE_WALK: begin
				cmd.free_step = 1'b1;
				if (!sts.walk_go) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RK_ZERO;
					state_n      = ST_RESP;
				end
			end
			ST_READ_WAIT: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = RK_LINK;
				state_n      = ST_RESP;
			end
			ST_RESP: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/block_chain_allocation_table_top.sv
// Top level of the block chain allocation table: joins controller and datapath.
// Depends on bcat_pkg, bcat_ctrl, bcat_datapath and bcat_ram.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   bcat_req_t  (req_type, block_count, entry_index)
//   rsp      out        rsp_valid/rsp_stall   bcat_rsp_t  (status, value)
//
// After reset a clearing pass writes every table entry to zero, with req stalled.
// Allocate: one counting scan and, on success, one linking scan, each reading the entries from
// index 1 upward. Free: a walk along the chain that zeroes each link. Read: one memory read.
// The link memory has a single read port, so the scans and the walk read one entry at a time.
// One finished result waits in the output register while the next item is taken in.
`default_nettype none

module block_chain_allocation_table_top #(
	parameter int ENTRIES = bcat_pkg::ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire bcat_pkg::bcat_req_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output bcat_pkg::bcat_rsp_t      rsp
);

	import bcat_pkg::*;

	bcat_cmd_t cmd;
	bcat_sts_t sts;

	bcat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bcat_datapath #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req_in (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

### rtl/core/bcat_checker.sv
// Port-level checks of the block chain allocation table, bound to the top level.
// Depends on bcat_pkg and block_chain_allocation_table_top.
`default_nettype none

module bcat_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_stall,
	input wire logic                rsp_valid,
	input wire logic                rsp_stall,
	input wire bcat_pkg::bcat_rsp_t rsp
);

	import bcat_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = req_valid && !req_stall;
	assign out_acc = rsp_valid && !rsp_stall;

	// Items taken in whose result has not yet been taken out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> req_stall)
		else $error("req not stalled after an item was accepted");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.value == 16'd0)
		else $error("failed allocate carries a nonzero value");

	a_no_extra_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 2'd0)
		else $error("result delivered with no item outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

endmodule

bind block_chain_allocation_table_top bcat_checker u_bcat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
